FILE: rtl/wsp_pkg.sv
// Shared constants and register codes for the wheel speed PID loop.
package wsp_pkg;

    // Moving-average depth; must be a power of two (2, 4, 8 or 16).
    localparam int AVG_DEPTH = 8;
    localparam int AVG_LOG2  = $clog2(AVG_DEPTH);
    localparam int PTR_W     = AVG_LOG2;

    // Encoder delta and speed scaling (853/256 ~ 100/30).
    localparam int COUNT_W   = 32;
    localparam int DELTA_W   = 16;
    localparam int SCALE_W   = 11;
    localparam logic signed [SCALE_W-1:0] SPEED_SCALE = 11'sd853;
    localparam int RAW_W     = DELTA_W + SCALE_W;
    localparam int SUM_W     = RAW_W + AVG_LOG2;

    // PID datapath widths.
    localparam int SPEED_W   = 32;
    localparam int ERR_W     = 33;
    localparam int DIFF_W    = 34;
    localparam int INTEG_W   = 48;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 32;
    localparam int INTEG_LO_W = 24;
    localparam int INTEG_HI_W = INTEG_W - INTEG_LO_W;
    localparam int PROD_P_W  = GAIN_W + ERR_W;
    localparam int PROD_D_W  = GAIN_W + DIFF_W;
    localparam int PROD_LO_W = GAIN_W + INTEG_LO_W + 1;
    localparam int PROD_HI_W = GAIN_W + INTEG_HI_W;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 8;
    localparam int DRIVE_W   = ACC_W - FRAC_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX    = 3'd5;

    // Input kinds carried on tuser.
    localparam logic ACT_PULSE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Pipeline depth between the input transfer and the output register.
    localparam int NUM_STAGES = 8;

endpackage

FILE: rtl/wheel_speed_pid_loop_top.sv
// Top level of the wheel speed loop: pulse counter, speed filter and PID pipeline.
// A control-tick transfer passes the pipeline stages and then the output register before it shows on m_tvalid.
// Throughput: one input transfer per cycle, pulses and ticks alike, while s_tready is high (it drops
// under m_tready back-pressure); the running history sum and the error integral update at every step.
// Pulses update the count at their transfer and produce no result.
// Reset (aresetn low, synchronous) clears count, history, integral and pipeline, and
// loads the registers with their defaults (full-range drive limits, zero gains).
module wheel_speed_pid_loop_top
    import wsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] forward, [7:1] zero
    input  logic [0:0]            s_tuser,   // [0] action
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata    // [31:0] speed_filtered, [63:32] drive_value
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [SPEED_W-1:0] target_speed_reg;
    logic signed [GAIN_W-1:0]  gain_prop_reg;
    logic signed [GAIN_W-1:0]  gain_integ_reg;
    logic signed [GAIN_W-1:0]  gain_deriv_reg;
    logic signed [LIMIT_W-1:0] drive_min_reg;
    logic signed [LIMIT_W-1:0] drive_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_speed_reg <= '0;
            gain_prop_reg    <= '0;
            gain_integ_reg   <= '0;
            gain_deriv_reg   <= '0;
            drive_min_reg    <= {1'b1, {(LIMIT_W-1){1'b0}}};
            drive_max_reg    <= {1'b0, {(LIMIT_W-1){1'b1}}};
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_TARGET_SPEED: target_speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_GAIN_PROP:    gain_prop_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_INTEG:   gain_integ_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_DERIV:   gain_deriv_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_DRIVE_MIN:    drive_min_reg    <= cfg_wdata[LIMIT_W-1:0];
                REG_DRIVE_MAX:    drive_max_reg    <= cfg_wdata[LIMIT_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it loads, so bubbles collapse and the input side keeps
    // moving while a finished result waits in the output register.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   en;
    logic [NUM_STAGES-1:0] fire;
    logic                  m_tvalid_reg;
    logic [63:0]           m_tdata_reg;

    always_comb begin
        en[NUM_STAGES] = !m_tvalid_reg || m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        fire = valid_reg & en[NUM_STAGES:1];
    end

    assign s_tready = en[0];

    logic in_xfer;
    logic tick_xfer;
    assign in_xfer   = s_tvalid && s_tready;
    assign tick_xfer = in_xfer && (s_tuser[0] == ACT_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid && (s_tuser[0] == ACT_TICK);
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (en[NUM_STAGES]) begin
                m_tvalid_reg <= valid_reg[NUM_STAGES-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Encoder pulse counter and tick delta (input transfer)
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]        pulse_count_reg;
    logic [COUNT_W-1:0]        last_count_reg;
    logic signed [COUNT_W-1:0] delta_full;
    logic signed [DELTA_W-1:0] delta_sat;

    always_comb begin
        delta_full = signed'(pulse_count_reg - last_count_reg);
        // Saturate the wrapped delta to 16 bits.
        if (delta_full > COUNT_W'(signed'(16'sh7fff))) begin
            delta_sat = 16'sh7fff;
        end else if (delta_full < COUNT_W'(signed'(16'sh8000))) begin
            delta_sat = 16'sh8000;
        end else begin
            delta_sat = delta_full[DELTA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_count_reg <= '0;
            last_count_reg  <= '0;
        end else if (in_xfer) begin
            if (s_tuser[0] == ACT_PULSE) begin
                if (s_tdata[0]) begin
                    pulse_count_reg <= pulse_count_reg + COUNT_W'(1);
                end else begin
                    pulse_count_reg <= pulse_count_reg - COUNT_W'(1);
                end
            end else begin
                last_count_reg <= pulse_count_reg;
            end
        end
    end

    // Stage 0: saturated delta
    logic signed [DELTA_W-1:0] st0_delta_reg;
    always_ff @(posedge aclk) begin
        if (en[0] && tick_xfer) begin
            st0_delta_reg <= delta_sat;
        end
    end

    // Stage 1: raw speed = delta * 853 (Q.8)
    logic signed [RAW_W-1:0] st1_raw_reg;
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            st1_raw_reg <= RAW_W'(st0_delta_reg) * RAW_W'(SPEED_SCALE);
        end
    end

    // Stage 2: running history sum
    logic signed [SUM_W-1:0] avg_sum_next;
    logic signed [SUM_W-1:0] st2_sum_reg;

    wsp_avg u_avg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (fire[1]),
        .raw_in   (st1_raw_reg),
        .sum_next (avg_sum_next)
    );

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            st2_sum_reg <= avg_sum_next;
        end
    end

    // Stage 3: filtered speed (sum / depth, toward zero) and error
    logic signed [SUM_W-1:0]   sum_biased;
    logic signed [SUM_W-1:0]   sum_quot;
    logic signed [SPEED_W-1:0] speed_now;
    logic signed [ERR_W-1:0]   err_now;
    logic signed [SPEED_W-1:0] st3_speed_reg;
    logic signed [ERR_W-1:0]   st3_err_reg;

    always_comb begin
        sum_biased = st2_sum_reg + (st2_sum_reg[SUM_W-1] ? SUM_W'(AVG_DEPTH - 1) : SUM_W'(0));
        sum_quot   = sum_biased >>> AVG_LOG2;
        speed_now  = SPEED_W'(sum_quot);
        err_now    = ERR_W'(target_speed_reg) - ERR_W'(speed_now);
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            st3_speed_reg <= speed_now;
            st3_err_reg   <= err_now;
        end
    end

    // Stage 4: integral and derivative term
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [DIFF_W-1:0]  diff_now;
    logic signed [SPEED_W-1:0] st4_speed_reg;
    logic signed [ERR_W-1:0]   st4_err_reg;
    logic signed [INTEG_W-1:0] st4_integ_reg;
    logic signed [DIFF_W-1:0]  st4_diff_reg;

    wsp_integ u_integ (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (fire[3]),
        .err_in     (st3_err_reg),
        .integ_next (integ_next),
        .diff       (diff_now)
    );

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            st4_speed_reg <= st3_speed_reg;
            st4_err_reg   <= st3_err_reg;
            st4_integ_reg <= integ_next;
            st4_diff_reg  <= diff_now;
        end
    end

    // Stage 5: gain products; split the integral into two halves
    logic signed [INTEG_LO_W:0]    integ_lo;
    logic signed [INTEG_HI_W-1:0]  integ_hi;
    logic signed [SPEED_W-1:0]     st5_speed_reg;
    logic signed [PROD_P_W-1:0]    st5_prod_p_reg;
    logic signed [PROD_D_W-1:0]    st5_prod_d_reg;
    logic signed [PROD_LO_W-1:0]   st5_prod_lo_reg;
    logic signed [PROD_HI_W-1:0]   st5_prod_hi_reg;

    assign integ_lo = signed'({1'b0, st4_integ_reg[INTEG_LO_W-1:0]});
    assign integ_hi = signed'(st4_integ_reg[INTEG_W-1:INTEG_LO_W]);

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            st5_speed_reg   <= st4_speed_reg;
            st5_prod_p_reg  <= PROD_P_W'(gain_prop_reg) * PROD_P_W'(st4_err_reg);
            st5_prod_d_reg  <= PROD_D_W'(gain_deriv_reg) * PROD_D_W'(st4_diff_reg);
            st5_prod_lo_reg <= PROD_LO_W'(gain_integ_reg) * PROD_LO_W'(integ_lo);
            st5_prod_hi_reg <= PROD_HI_W'(gain_integ_reg) * PROD_HI_W'(integ_hi);
        end
    end

    // Stage 6: partial sums
    logic signed [ACC_W-1:0]   integ_term;
    logic signed [ACC_W-1:0]   pd_term;
    logic signed [SPEED_W-1:0] st6_speed_reg;
    logic signed [ACC_W-1:0]   st6_integ_reg;
    logic signed [ACC_W-1:0]   st6_pd_reg;

    always_comb begin
        integ_term = (ACC_W'(st5_prod_hi_reg) <<< INTEG_LO_W) + ACC_W'(st5_prod_lo_reg);
        pd_term    = ACC_W'(st5_prod_p_reg) + ACC_W'(st5_prod_d_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            st6_speed_reg <= st5_speed_reg;
            st6_integ_reg <= integ_term;
            st6_pd_reg    <= pd_term;
        end
    end

    // Stage 7: full accumulator, floor by 256 (drop fraction bits)
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [SPEED_W-1:0] st7_speed_reg;
    logic signed [DRIVE_W-1:0] st7_drive_reg;

    assign acc_sum = st6_integ_reg + st6_pd_reg;

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            st7_speed_reg <= st6_speed_reg;
            st7_drive_reg <= acc_sum[ACC_W-1:FRAC_W];
        end
    end

    // ------------------------------------------------------------------
    // Output register: clamp to drive_max first, then drive_min, so the
    // low limit wins when the limits cross.
    // ------------------------------------------------------------------
    logic signed [DRIVE_W-1:0] lim_max;
    logic signed [DRIVE_W-1:0] lim_min;
    logic signed [DRIVE_W-1:0] drive_hi_clamped;
    logic signed [DRIVE_W-1:0] drive_clamped;

    always_comb begin
        lim_max          = DRIVE_W'(drive_max_reg);
        lim_min          = DRIVE_W'(drive_min_reg);
        drive_hi_clamped = (st7_drive_reg > lim_max) ? lim_max : st7_drive_reg;
        drive_clamped    = (drive_hi_clamped < lim_min) ? lim_min : drive_hi_clamped;
    end

    always_ff @(posedge aclk) begin
        if (en[NUM_STAGES]) begin
            m_tdata_reg <= {drive_clamped[LIMIT_W-1:0], st7_speed_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/wsp_avg.sv
// Moving-average history: ring of raw speeds and running sum.
module wsp_avg
    import wsp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic signed [RAW_W-1:0] raw_in,
    output logic signed [SUM_W-1:0] sum_next
);

    logic signed [RAW_W-1:0] hist_reg [AVG_DEPTH];
    logic [PTR_W-1:0]        ptr_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [RAW_W-1:0] oldest;

    // Add the new raw speed and drop the one it replaces.
    always_comb begin
        oldest   = hist_reg[ptr_reg];
        sum_next = sum_reg + SUM_W'(raw_in) - SUM_W'(oldest);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            ptr_reg <= '0;
            sum_reg <= '0;
        end else if (step) begin
            hist_reg[ptr_reg] <= raw_in;
            sum_reg           <= sum_next;
            if (ptr_reg == PTR_W'(AVG_DEPTH - 1)) begin
                ptr_reg <= '0;
            end else begin
                ptr_reg <= ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

FILE: rtl/wsp_integ.sv
// Saturating error integral and derivative difference for the PID.
module wsp_integ
    import wsp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic signed [ERR_W-1:0]   err_in,
    output logic signed [INTEG_W-1:0] integ_next,
    output logic signed [DIFF_W-1:0]  diff
);

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [INTEG_W:0]   integ_sum;

    always_comb begin
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_in);
        // Hold at the limit when the sum leaves the 48-bit range.
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
        diff = DIFF_W'(err_in) - DIFF_W'(prev_err_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else if (step) begin
            integ_reg    <= integ_next;
            prev_err_reg <= err_in;
        end
    end

endmodule
